### rtl/core/tta_pkg.sv
// Shared types and constants for the tensor transpose address generator.
// Holds register indexes, status codes, sequencer states and the beat record.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package tta_pkg;

  localparam int MAX_AXES_DEF   = 4;
  localparam int DIM_BITS_DEF   = 16;
  localparam int REG_AXES       = 4;
  localparam int RANK_W         = 3;
  localparam int SIZE_W         = 16;
  localparam int ORDER_W        = 8;
  localparam int DATA_W         = 32;
  localparam int APB_DATA_W     = 32;
  localparam int APB_ADDR_W     = 5;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [RANK_W-1:0]  RANK_RST  = 3'd1;
  localparam logic [SIZE_W-1:0]  SIZE_RST  = 16'd1;
  localparam logic [ORDER_W-1:0] ORDER_RST = 8'd228;

  typedef enum logic [2:0] {
    REG_RANK   = 3'd0,
    REG_SIZE_A = 3'd1,
    REG_SIZE_B = 3'd2,
    REG_SIZE_C = 3'd3,
    REG_SIZE_D = 3'd4,
    REG_ORDER  = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_ORDER = 2'd1,
    ST_TOO_LARGE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    DRV_IDLE,
    DRV_START,
    DRV_STRIDE,
    DRV_REWIND,
    DRV_DELTA
  } drv_state_t;

  typedef struct packed {
    logic    busy;
    status_t status;
  } drv_info_t;

  typedef struct packed {
    status_t             status;
    logic                last;
    logic [DATA_W-1:0]   element;
    logic [DATA_W-1:0]   dest;
  } beat_t;

endpackage

`default_nettype wire

### rtl/core/tensor_transpose_address_gen_top.sv
// Top level of the tensor transpose address generator: register file and block wiring.
// Depends on tta_pkg, tta_derive, tta_front, tta_queue and tta_back.
//
// Elements of a tensor of up to MAX_AXES axes enter in row-major order, one per beat, and
// leave in the same order with their linear index in the permuted output tensor, a last
// flag on the final element and a status code. In steady state the block takes one beat
// per clock while in_tready is high; a beat goes through the queue and the output register,
// and the two-entry queue lets the input flow on while the output stalls. After reset and
// each write to a mapped register, a setup pass of START, STRIDE, REWIND and DELTA steps
// derives the strides, one multiply per axis per clock, with in_tready low; the write also
// restarts the tensor at its first element. Write registers only while no beats are in flight.
`default_nettype none

module tensor_transpose_address_gen_top #(
  parameter int MAX_AXES = tta_pkg::MAX_AXES_DEF,
  parameter int DIM_BITS = tta_pkg::DIM_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // element_bits
  input  wire logic [tta_pkg::DATA_W-1:0]       in_tdata,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // dest_index, element_out
  output logic      [2*tta_pkg::DATA_W-1:0]     out_tdata,
  output logic                                  out_tlast,
  // status
  output logic      [1:0]                       out_tuser,
  input  wire logic                             cfg_psel,
  input  wire logic                             cfg_penable,
  input  wire logic                             cfg_pwrite,
  input  wire logic [tta_pkg::APB_ADDR_W-1:0]   cfg_paddr,
  input  wire logic [tta_pkg::APB_DATA_W-1:0]   cfg_pwdata,
  output logic      [tta_pkg::APB_DATA_W-1:0]   cfg_prdata,
  output logic                                  cfg_pready
);
  import tta_pkg::*;

  logic [RANK_W-1:0]  rank_r;
  logic [SIZE_W-1:0]  size_r [REG_AXES];
  logic [ORDER_W-1:0] order_r;

  reg_idx_t            reg_idx;
  logic                cfg_wr;
  logic                cfg_hit;

  logic [DIM_BITS-1:0] ext_m1 [MAX_AXES];
  logic [DATA_W-1:0]   delta  [MAX_AXES];
  drv_info_t           info;
  logic                push, pop, q_full, q_valid;
  beat_t               f_beat, q_beat;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_idx    = reg_idx_t'(cfg_paddr[APB_ADDR_W-1:2]);

  always_comb begin
    case (reg_idx)
      REG_RANK, REG_SIZE_A, REG_SIZE_B, REG_SIZE_C, REG_SIZE_D, REG_ORDER: cfg_hit = cfg_wr;
      default: cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rank_r  <= RANK_RST;
      for (int i = 0; i < REG_AXES; i++) begin
        size_r[i] <= SIZE_RST;
      end
      order_r <= ORDER_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_RANK:   rank_r    <= cfg_pwdata[RANK_W-1:0];
        REG_SIZE_A: size_r[0] <= cfg_pwdata[SIZE_W-1:0];
        REG_SIZE_B: size_r[1] <= cfg_pwdata[SIZE_W-1:0];
        REG_SIZE_C: size_r[2] <= cfg_pwdata[SIZE_W-1:0];
        REG_SIZE_D: size_r[3] <= cfg_pwdata[SIZE_W-1:0];
        REG_ORDER:  order_r   <= cfg_pwdata[ORDER_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_RANK:   cfg_prdata = APB_DATA_W'(rank_r);
      REG_SIZE_A: cfg_prdata = APB_DATA_W'(size_r[0]);
      REG_SIZE_B: cfg_prdata = APB_DATA_W'(size_r[1]);
      REG_SIZE_C: cfg_prdata = APB_DATA_W'(size_r[2]);
      REG_SIZE_D: cfg_prdata = APB_DATA_W'(size_r[3]);
      REG_ORDER:  cfg_prdata = APB_DATA_W'(order_r);
      default:    cfg_prdata = '0;
    endcase
  end

  tta_derive #(
    .MAX_AXES (MAX_AXES),
    .DIM_BITS (DIM_BITS)
  ) u_derive (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (cfg_hit),
    .rank       (rank_r),
    .size_axis  (size_r),
    .axis_order (order_r),
    .ext_m1     (ext_m1),
    .delta      (delta),
    .info       (info)
  );

  tta_front #(
    .MAX_AXES (MAX_AXES),
    .DIM_BITS (DIM_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .clear      (cfg_hit),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .ext_m1     (ext_m1),
    .delta      (delta),
    .info       (info),
    .queue_full (q_full),
    .push       (push),
    .beat       (f_beat)
  );

  tta_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .beat_in  (f_beat),
    .full     (q_full),
    .pop      (pop),
    .valid    (q_valid),
    .beat_out (q_beat)
  );

  tta_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_beat     (q_beat),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

### rtl/core/tta_derive.sv
// Shape decoder: turns the configuration registers into per-axis extents and index steps.
// A short sequencer with one stride multiply per cycle runs after reset and each start.
// Depends on tta_pkg.
`default_nettype none

module tta_derive #(
  parameter int MAX_AXES = tta_pkg::MAX_AXES_DEF,
  parameter int DIM_BITS = tta_pkg::DIM_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [tta_pkg::RANK_W-1:0]  rank,
  input  wire logic [tta_pkg::SIZE_W-1:0]  size_axis [tta_pkg::REG_AXES],
  input  wire logic [tta_pkg::ORDER_W-1:0] axis_order,
  output logic      [DIM_BITS-1:0]         ext_m1 [MAX_AXES],
  output logic      [tta_pkg::DATA_W-1:0]  delta [MAX_AXES],
  output tta_pkg::drv_info_t               info
);
  import tta_pkg::*;

  localparam int             AW         = (MAX_AXES > 1) ? $clog2(MAX_AXES) : 1;
  localparam int             PW         = 33 + DIM_BITS;
  localparam logic [3:0]     MAX_AXES_V = 4'(MAX_AXES);
  localparam logic [AW-1:0]  LAST_IDX   = AW'(MAX_AXES - 1);
  localparam logic [32:0]    TOTAL_LIM  = {1'b1, 32'd0};
  localparam logic [32:0]    TOTAL_SAT  = {1'b1, 31'd0, 1'b1};

  logic [3:0]          r_eff;
  logic [DIM_BITS-1:0] ext  [MAX_AXES];
  logic [3:0]          ord4 [MAX_AXES];
  logic [AW-1:0]       ord  [MAX_AXES];
  logic [MAX_AXES-1:0] seen;
  logic                order_ok;

  drv_state_t          state_r, state_nxt;
  logic [AW-1:0]       cnt_r, cnt_nxt;
  logic [AW-1:0]       cnt_m1;

  logic [DATA_W-1:0]   ostride_r [MAX_AXES];
  logic [DATA_W-1:0]   istride_r [MAX_AXES];
  logic [DATA_W-1:0]   rewind_r  [MAX_AXES];
  logic [DATA_W-1:0]   delta_r   [MAX_AXES];
  logic [DIM_BITS-1:0] ext_m1_r  [MAX_AXES];
  logic [DATA_W-1:0]   acc_r;
  logic [32:0]         total_r;
  status_t             status_r;

  logic [PW-1:0]       total_prod;
  logic [32:0]         total_nxt;
  logic [DATA_W-1:0]   stride_prod;
  logic [DIM_BITS-1:0] ext_sel;
  logic [DATA_W-1:0]   rew_prod;

  always_comb begin
    r_eff = {1'b0, rank};
    if (rank == '0) begin
      r_eff = 4'd1;
    end else if ({1'b0, rank} > MAX_AXES_V) begin
      r_eff = MAX_AXES_V;
    end
  end

  for (genvar g = 0; g < MAX_AXES; g++) begin : g_axis
    if (g < REG_AXES) begin : g_reg
      logic [31:0]         size_wide;
      logic [DIM_BITS-1:0] size_cut;
      logic                in_use;
      assign size_wide = 32'(size_axis[g]);
      assign size_cut  = size_wide[DIM_BITS-1:0];
      assign in_use    = (4'(g) < r_eff);
      assign ext[g]    = (in_use && (size_cut != '0)) ? size_cut : DIM_BITS'(1);
      assign ord4[g]   = in_use ? 4'(axis_order[2*g +: 2]) : 4'(g);
    end else begin : g_pad
      assign ext[g]  = DIM_BITS'(1);
      assign ord4[g] = 4'(g);
    end
  end

  always_comb begin
    seen     = '0;
    order_ok = 1'b1;
    for (int i = 0; i < MAX_AXES; i++) begin
      if (4'(i) < r_eff) begin
        if (ord4[i] >= r_eff) begin
          order_ok = 1'b0;
        end else if (seen[AW'(ord4[i])]) begin
          order_ok = 1'b0;
        end else begin
          seen[AW'(ord4[i])] = 1'b1;
        end
      end
    end
    for (int i = 0; i < MAX_AXES; i++) begin
      ord[i] = order_ok ? AW'(ord4[i]) : AW'(i);
    end
  end

  assign cnt_m1      = cnt_r - 1'b1;
  assign total_prod  = PW'(total_r) * PW'(ext[cnt_r]);
  assign total_nxt   = (total_prod > PW'(TOTAL_LIM)) ? TOTAL_SAT : total_prod[32:0];
  assign stride_prod = 32'(ostride_r[cnt_r] * 32'(ext[ord[cnt_r]]));
  assign ext_sel     = ext[ord[cnt_r]];
  assign rew_prod    = 32'(32'(ext_sel - 1'b1) * ostride_r[cnt_r]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DRV_START;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      DRV_IDLE: begin
      end
      DRV_START: begin
        state_nxt = DRV_STRIDE;
        cnt_nxt   = LAST_IDX;
      end
      DRV_STRIDE: begin
        if (cnt_r == '0) begin
          state_nxt = DRV_REWIND;
          cnt_nxt   = LAST_IDX;
        end else begin
          cnt_nxt = cnt_m1;
        end
      end
      DRV_REWIND: begin
        if (cnt_r == '0) begin
          state_nxt = DRV_DELTA;
          cnt_nxt   = LAST_IDX;
        end else begin
          cnt_nxt = cnt_m1;
        end
      end
      DRV_DELTA: begin
        if (cnt_r == '0) begin
          state_nxt = DRV_IDLE;
        end else begin
          cnt_nxt = cnt_m1;
        end
      end
      default: begin
        state_nxt = DRV_IDLE;
      end
    endcase
    if (start) begin
      state_nxt = DRV_START;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      DRV_START: begin
        ostride_r[MAX_AXES-1] <= 32'd1;
        total_r               <= 33'd1;
        acc_r                 <= '0;
      end
      DRV_STRIDE: begin
        total_r <= total_nxt;
        if (cnt_r != '0) begin
          ostride_r[cnt_m1] <= stride_prod;
        end
      end
      DRV_REWIND: begin
        istride_r[ord[cnt_r]] <= ostride_r[cnt_r];
        rewind_r[ord[cnt_r]]  <= rew_prod;
      end
      DRV_DELTA: begin
        delta_r[cnt_r] <= istride_r[cnt_r] - acc_r;
        acc_r          <= acc_r + rewind_r[cnt_r];
        if (cnt_r == '0) begin
          for (int i = 0; i < MAX_AXES; i++) begin
            ext_m1_r[i] <= ext[i] - 1'b1;
          end
          if (!order_ok) begin
            status_r <= ST_BAD_ORDER;
          end else if (total_r > TOTAL_LIM) begin
            status_r <= ST_TOO_LARGE;
          end else begin
            status_r <= ST_OK;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign ext_m1      = ext_m1_r;
  assign delta       = delta_r;
  assign info.busy   = (state_r != DRV_IDLE);
  assign info.status = status_r;

endmodule

`default_nettype wire

### rtl/core/tta_front.sv
// Front end: accepts element beats and steps the per-axis coordinate counters.
// Each accepted beat is tagged with its destination index and pushed to the queue.
// Depends on tta_pkg.
`default_nettype none

module tta_front #(
  parameter int MAX_AXES = tta_pkg::MAX_AXES_DEF,
  parameter int DIM_BITS = tta_pkg::DIM_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       clear,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic [tta_pkg::DATA_W-1:0] in_tdata,
  input  wire logic [DIM_BITS-1:0]        ext_m1 [MAX_AXES],
  input  wire logic [tta_pkg::DATA_W-1:0] delta [MAX_AXES],
  input  wire tta_pkg::drv_info_t         info,
  input  wire logic                       queue_full,
  output logic                            push,
  output tta_pkg::beat_t                  beat
);
  import tta_pkg::*;

  localparam int AW = (MAX_AXES > 1) ? $clog2(MAX_AXES) : 1;

  logic [DIM_BITS-1:0] pos_r   [MAX_AXES];
  logic [DIM_BITS-1:0] pos_nxt [MAX_AXES];
  logic [DATA_W-1:0]   run_r, run_nxt;
  logic                last;
  logic [AW-1:0]       sel;
  logic                accept;

  assign in_tready = !info.busy && !queue_full;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    last = 1'b1;
    sel  = '0;
    for (int i = 0; i < MAX_AXES; i++) begin
      if (pos_r[i] != ext_m1[i]) begin
        last = 1'b0;
        sel  = AW'(i);
      end
    end
    run_nxt = last ? '0 : run_r + delta[sel];
    for (int k = 0; k < MAX_AXES; k++) begin
      if (last || (AW'(k) > sel)) begin
        pos_nxt[k] = '0;
      end else if (AW'(k) == sel) begin
        pos_nxt[k] = pos_r[k] + 1'b1;
      end else begin
        pos_nxt[k] = pos_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      for (int i = 0; i < MAX_AXES; i++) begin
        pos_r[i] <= '0;
      end
      run_r <= '0;
    end else if (accept) begin
      pos_r <= pos_nxt;
      run_r <= run_nxt;
    end
  end

  assign push         = accept;
  assign beat.status  = info.status;
  assign beat.last    = last;
  assign beat.element = in_tdata;
  assign beat.dest    = run_r;

endmodule

`default_nettype wire

### rtl/core/tta_queue.sv
// Short first-in first-out queue of tagged beats between the front and the back end.
// Depends on tta_pkg.
`default_nettype none

module tta_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire tta_pkg::beat_t beat_in,
  output logic                full,
  input  wire logic           pop,
  output logic                valid,
  output tta_pkg::beat_t      beat_out
);
  import tta_pkg::*;

  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [QW-1:0] PTR_LAST = QW'(QUEUE_DEPTH - 1);
  localparam logic [QW:0]   CNT_FULL = (QW + 1)'(QUEUE_DEPTH);

  beat_t        mem_r [QUEUE_DEPTH];
  logic [QW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QW:0]   count_r;

  assign full     = (count_r == CNT_FULL);
  assign valid    = (count_r != '0);
  assign beat_out = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= beat_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/core/tta_back.sv
// Back end: output register that drives the result stream from the queue head.
// Depends on tta_pkg.
`default_nettype none

module tta_back (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         q_valid,
  input  wire tta_pkg::beat_t               q_beat,
  output logic                              pop,
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  output logic [2*tta_pkg::DATA_W-1:0]      out_tdata,
  output logic                              out_tlast,
  output logic [1:0]                        out_tuser
);
  import tta_pkg::*;

  logic  out_valid_r;
  beat_t out_beat_r;

  assign pop = q_valid && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_beat_r <= q_beat;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_beat_r.element, out_beat_r.dest};
  assign out_tlast  = out_beat_r.last;
  assign out_tuser  = out_beat_r.status;

endmodule

`default_nettype wire

### sim/transpose_index_checker.sv
`timescale 1ns / 100ps
// Checker for the tensor transpose address generator: follows register writes and accepted
// element beats, predicts every output beat and compares it field by field.
// Depends on tta_pkg for the register indexes, status codes and the beat record.
module transpose_index_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  // element_bits
  input  logic [31:0]                     in_tdata,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  // dest_index, element_out
  input  logic [63:0]                     out_tdata,
  input  logic                            out_tlast,
  // status
  input  logic [1:0]                      out_tuser,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [tta_pkg::APB_ADDR_W-1:0]  cfg_paddr,
  input  logic [31:0]                     cfg_pwdata,
  input  logic                            cfg_pready,
  output int                              mismatches,
  output int                              outstanding
);
  import tta_pkg::*;

  localparam int AXES = MAX_AXES_DEF;
  localparam logic [63:0] ELEM_LIMIT = 64'h1_0000_0000;

  logic [RANK_W-1:0]  rank_q;
  logic [SIZE_W-1:0]  size_q[REG_AXES];
  logic [ORDER_W-1:0] order_q;
  logic [31:0]        extent_q[AXES];
  logic [31:0]        in_stride_q[AXES];
  status_t            status_q;
  logic [31:0]        coord_q[AXES];
  logic [31:0]        dest_q;
  beat_t              pending_dests[$];

  task automatic clear_coords();
    for (int i = 0; i < AXES; i++) coord_q[i] = '0;
    dest_q = '0;
  endtask

  task automatic derive_strides();
    int eff_rank;
    int src[AXES];
    logic [31:0] out_stride[AXES];
    logic [AXES-1:0] seen;
    logic [63:0] total;
    bit ok;
    if (rank_q == 0) eff_rank = 1;
    else if (rank_q > AXES) eff_rank = AXES;
    else eff_rank = int'(rank_q);
    for (int i = 0; i < AXES; i++) begin
      extent_q[i] = 32'd1;
      src[i] = i;
      if (i < eff_rank) begin
        if (size_q[i] != 0) extent_q[i] = 32'(size_q[i]);
        src[i] = int'(order_q[2*i +: 2]);
      end
    end
    ok = 1'b1;
    seen = '0;
    for (int i = 0; i < eff_rank; i++) begin
      if (src[i] >= eff_rank || seen[src[i]]) ok = 1'b0;
      else seen[src[i]] = 1'b1;
    end
    if (!ok) begin
      for (int i = 0; i < AXES; i++) src[i] = i;
    end
    out_stride[AXES-1] = 32'd1;
    for (int i = AXES - 2; i >= 0; i--) out_stride[i] = out_stride[i+1] * extent_q[src[i+1]];
    for (int i = 0; i < AXES; i++) in_stride_q[src[i]] = out_stride[i];
    total = 64'd1;
    for (int i = 0; i < AXES; i++) begin
      total = total * 64'(extent_q[i]);
      if (total > ELEM_LIMIT) total = ELEM_LIMIT + 1;
    end
    if (!ok) status_q = ST_BAD_ORDER;
    else if (total > ELEM_LIMIT) status_q = ST_TOO_LARGE;
    else status_q = ST_OK;
  endtask

  task automatic reset_model();
    rank_q = RANK_RST;
    for (int i = 0; i < REG_AXES; i++) size_q[i] = SIZE_RST;
    order_q = ORDER_RST;
    clear_coords();
    derive_strides();
  endtask

  task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
    bit hit;
    hit = 1'b1;
    case (idx)
      REG_RANK:   rank_q = value[RANK_W-1:0];
      REG_SIZE_A: size_q[0] = value[SIZE_W-1:0];
      REG_SIZE_B: size_q[1] = value[SIZE_W-1:0];
      REG_SIZE_C: size_q[2] = value[SIZE_W-1:0];
      REG_SIZE_D: size_q[3] = value[SIZE_W-1:0];
      REG_ORDER:  order_q = value[ORDER_W-1:0];
      default:    hit = 1'b0;
    endcase
    if (hit) begin
      clear_coords();
      derive_strides();
    end
  endtask

  // The destination index moves by the stride of the stepped axis; every axis that wraps
  // takes its own contribution back out.
  task automatic predict_dest(input logic [31:0] element);
    beat_t b;
    bit final_elem;
    bit stepped;
    final_elem = 1'b1;
    for (int i = 0; i < AXES; i++) begin
      if (coord_q[i] + 32'd1 != extent_q[i]) final_elem = 1'b0;
    end
    b.dest = dest_q;
    b.element = element;
    b.last = final_elem;
    b.status = status_q;
    pending_dests.push_back(b);
    if (final_elem) begin
      clear_coords();
    end else begin
      stepped = 1'b0;
      for (int i = AXES - 1; i >= 0; i--) begin
        if (!stepped) begin
          if (coord_q[i] + 32'd1 < extent_q[i]) begin
            coord_q[i] = coord_q[i] + 32'd1;
            dest_q = dest_q + in_stride_q[i];
            stepped = 1'b1;
          end else begin
            dest_q = dest_q - coord_q[i] * in_stride_q[i];
            coord_q[i] = '0;
          end
        end
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches = mismatches + 1;
    end
  endtask

  always @(posedge clk) begin : watch
    beat_t want;
    if (!rst_n) begin
      reset_model();
      pending_dests.delete();
      mismatches = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (pending_dests.size() == 0) begin
          $display("%0t: output beat with nothing expected, expected none, actual %h %b %h",
                   $time, out_tdata, out_tlast, out_tuser);
          mismatches = mismatches + 1;
        end else begin
          want = pending_dests.pop_front();
          check_field("dest_index", want.dest, out_tdata[31:0]);
          check_field("element_out", want.element, out_tdata[63:32]);
          check_field("last_of_tensor", 32'(want.last), 32'(out_tlast));
          check_field("status", 32'(want.status), 32'(out_tuser));
        end
      end
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        write_register(cfg_paddr[4:2], cfg_pwdata);
      end
      if (in_tvalid && in_tready) predict_dest(in_tdata);
    end
    outstanding = pending_dests.size();
  end

endmodule

### sim/tensor_transpose_address_gen_top_tb.sv
`timescale 1ns / 100ps
// Testbench top for the tensor transpose address generator: clock, reset, register setup
// and element stimulus with random idling, and the final verdict.
// Depends on tta_pkg, the block's RTL and transpose_index_checker.
module tensor_transpose_address_gen_top_tb;
  import tta_pkg::*;

  localparam logic [2:0] SPARE_REG_LO = 3'd6;
  localparam logic [2:0] SPARE_REG_HI = 3'd7;
  localparam int RANDOM_ITEMS = 1850;
  localparam int QUIET_FROM = 1600;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic [31:0] in_tdata = '0;
  logic        out_tready = 1'b0;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  wire         in_tready;
  wire         out_tvalid;
  wire  [63:0] out_tdata;
  wire         out_tlast;
  wire  [1:0]  out_tuser;
  wire  [31:0] cfg_prdata;
  wire         cfg_pready;
  int          mismatches;
  int          outstanding;
  int          gap_pct = 0;
  int          stall_pct = 0;
  int          sent = 0;
  logic [2:0]  rank_w = RANK_RST;
  logic [15:0] size_w[4] = '{SIZE_RST, SIZE_RST, SIZE_RST, SIZE_RST};
  logic [7:0]  order_w = ORDER_RST;

  always #6 clk = ~clk;

  tensor_transpose_address_gen_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  transpose_index_checker index_check (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_pready(cfg_pready),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  task automatic send_element(input logic [31:0] data);
    if (gap_pct > 0 && sent < QUIET_FROM && $urandom_range(0, 99) < gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= data;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic send_run(input int count, input int pause_at);
    for (int k = 0; k < count; k++) begin
      if (k == pause_at) drain();
      case ($urandom_range(0, 15))
        0:       send_element('0);
        1:       send_element('1);
        default: send_element($urandom);
      endcase
    end
  endtask

  // Bits above the register's width carry random junk.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] field, input int width);
    logic [31:0] word;
    word = $urandom;
    if (width > 0) word = (word << width) | field;
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= word;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic configure(input logic [2:0] r, input logic [15:0] a, input logic [15:0] b,
                           input logic [15:0] c, input logic [15:0] d, input logic [7:0] o,
                           input logic [5:0] which);
    drain();
    if (which[REG_RANK]) begin
      rank_w = r;
      write_reg(REG_RANK, 32'(r), RANK_W);
    end
    if (which[REG_SIZE_A]) begin
      size_w[0] = a;
      write_reg(REG_SIZE_A, 32'(a), SIZE_W);
    end
    if (which[REG_SIZE_B]) begin
      size_w[1] = b;
      write_reg(REG_SIZE_B, 32'(b), SIZE_W);
    end
    if (which[REG_SIZE_C]) begin
      size_w[2] = c;
      write_reg(REG_SIZE_C, 32'(c), SIZE_W);
    end
    if (which[REG_SIZE_D]) begin
      size_w[3] = d;
      write_reg(REG_SIZE_D, 32'(d), SIZE_W);
    end
    if (which[REG_ORDER]) begin
      order_w = o;
      write_reg(REG_ORDER, 32'(o), ORDER_W);
    end
  endtask

  function automatic int axes_in_use(input logic [2:0] r);
    if (r == 0) return 1;
    if (r > 4) return 4;
    return int'(r);
  endfunction

  function automatic longint unsigned tensor_length();
    longint unsigned n;
    n = 1;
    for (int i = 0; i < axes_in_use(rank_w); i++) begin
      if (size_w[i] != 0) n = n * 64'(size_w[i]);
    end
    return n;
  endfunction

  function automatic logic [7:0] random_order(input int r);
    int perm[4];
    int j;
    int t;
    logic [7:0] o;
    for (int i = 0; i < 4; i++) perm[i] = i;
    for (int i = r - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = perm[i];
      perm[i] = perm[j];
      perm[j] = t;
    end
    o = 8'($urandom);
    for (int i = 0; i < r; i++) o[2*i +: 2] = 2'(perm[i]);
    return o;
  endfunction

  function automatic logic [15:0] random_size();
    case ($urandom_range(0, 19))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom);
      default: return 16'($urandom_range(1, 5));
    endcase
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 5;
      default: return 25;
    endcase
  endfunction

  task automatic random_config();
    logic [2:0] r;
    logic [7:0] o;
    if ($urandom_range(0, 9) == 0) r = 3'($urandom_range(0, 7));
    else r = 3'($urandom_range(1, 4));
    if ($urandom_range(0, 3) == 0) o = 8'($urandom);
    else o = random_order(axes_in_use(r));
    configure(r, random_size(), random_size(), random_size(), random_size(), o,
              6'($urandom_range(1, 63)));
  endtask

  initial begin : receiver
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (stall_pct > 0 && sent < QUIET_FROM && $urandom_range(0, 99) < stall_pct) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  initial begin : stimulus
    longint unsigned len;
    int count;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset shape: every element is a whole tensor.
    send_element('0);
    send_element('1);
    // Three axes permuted, the fourth extent ignored; pause halfway for the output to empty.
    configure(3'd3, 16'd2, 16'd3, 16'd2, 16'hFFFF, 8'hD2, '1);
    send_run(12, 6);
    // Rank above the axis count, reversed order and a zero extent.
    configure(3'd7, 16'd1, 16'd1, 16'd2, 16'd0, 8'h1B, '1);
    send_run(2, -1);
    // Rank zero with an order that is not a permutation.
    configure(3'd0, 16'd3, 16'd1, 16'd1, 16'd1, 8'h05, '1);
    send_run(3, -1);
    // Oversized shape; a write to an unmapped register must not restart the tensor.
    configure(3'd4, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hE4, '1);
    send_run(3, -1);
    drain();
    write_reg(SPARE_REG_HI, '0, 0);
    send_run(2, -1);
    // A bad order outranks an oversized shape.
    configure(rank_w, size_w[0], size_w[1], size_w[2], size_w[3], 8'h00,
              6'(1 << REG_ORDER));
    send_run(1, -1);

    while (sent < RANDOM_ITEMS) begin
      if (sent >= QUIET_FROM) begin
        gap_pct = 0;
        stall_pct = 0;
      end else begin
        gap_pct = pick_pct();
        stall_pct = pick_pct();
      end
      random_config();
      if ($urandom_range(0, 15) == 0) begin
        write_reg($urandom_range(0, 1) ? SPARE_REG_LO : SPARE_REG_HI, '0, 0);
      end
      len = tensor_length();
      if (len <= 300 && $urandom_range(0, 4) != 0) count = int'(len) * $urandom_range(1, 2);
      else count = $urandom_range(1, 40);
      if (count > RANDOM_ITEMS - sent) count = RANDOM_ITEMS - sent;
      send_run(count, ($urandom_range(0, 3) == 0) ? count / 2 : -1);
    end

    drain();
    repeat (20) @(negedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
